@@ sv/fls_pkg.sv @@
// Shared types, constants and coefficient tables for the Fourier sensor linearizer.
// No dependencies; every other file imports this package.
`default_nettype none

package fls_pkg;

   // Field widths
   localparam int SampleWidth   = 16;
   localparam int PhaseWidth    = 32;
   localparam int TrigWidth     = 32;
   localparam int CoefWidth     = 32;
   localparam int AccWidth      = 36;
   localparam int PosWidth      = 24;

   // Register stages through one sine unit, and through one harmonic cell
   localparam int SineLatency   = 10;
   localparam int CellLatency   = SineLatency + 2;

   // Parameter defaults
   localparam int SampleBitsDefault    = 16;
   localparam int HarmonicCountDefault = 6;

   localparam logic [PhaseWidth-1:0] QuarterTurn = PhaseWidth'(1) << 30;
   localparam logic signed [PosWidth-1:0] PosMax = {1'b0, {(PosWidth-1){1'b1}}};
   localparam logic signed [PosWidth-1:0] PosMin = {1'b1, {(PosWidth-1){1'b0}}};

   // Sensor codes
   localparam logic SensorFirst  = 1'b0;
   localparam logic SensorSecond = 1'b1;

   typedef struct packed {
      logic                   sensor_select;
      logic [SampleWidth-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [PosWidth-1:0] position;
      logic                       saturated;
   } rsp_type;

   // Data handed from cell to cell
   typedef struct packed {
      logic                       sel;
      logic [PhaseWidth-1:0]      theta;
      logic signed [AccWidth-1:0] acc;
   } cell_data_type;

   // Phase step per 16-bit count, in 2^-32 turn units
   function automatic logic [15:0] phase_step(input logic sel);
      logic [15:0] step;
      unique case (sel)
         SensorFirst:  step = 16'd50793;
         SensorSecond: step = 16'd62204;
         default:      step = 16'd50793;
      endcase
      return step;
   endfunction

   // Odd Taylor terms of sin(pi/2 * t), Q2.30
   function automatic logic signed [TrigWidth-1:0] sine_poly(input logic [2:0] idx);
      logic signed [TrigWidth-1:0] c;
      unique case (idx)
         3'd0:    c = 32'sd1686629713;
         3'd1:    c = -32'sd693598668;
         3'd2:    c = 32'sd85569306;
         3'd3:    c = -32'sd5026995;
         3'd4:    c = 32'sd172272;
         3'd5:    c = -32'sd3864;
         3'd6:    c = 32'sd61;
         default: c = '0;
      endcase
      return c;
   endfunction

   // a0, then a_k, b_k for k = 1..6, Q8.24
   function automatic logic signed [CoefWidth-1:0] fit_coef(input logic sel,
                                                            input logic [3:0] idx);
      logic signed [CoefWidth-1:0] c;
      if (sel == SensorFirst) begin
         unique case (idx)
            4'd0:    c = 32'sd442398432;
            4'd1:    c = 32'sd717936777;
            4'd2:    c = -32'sd206774452;
            4'd3:    c = 32'sd451869143;
            4'd4:    c = -32'sd327665194;
            4'd5:    c = 32'sd189836727;
            4'd6:    c = -32'sd279029076;
            4'd7:    c = 32'sd41763426;
            4'd8:    c = -32'sd153573973;
            4'd9:    c = -32'sd3615084;
            4'd10:   c = -32'sd53356923;
            4'd11:   c = -32'sd4298558;
            4'd12:   c = -32'sd8993176;
            default: c = '0;
         endcase
      end else begin
         unique case (idx)
            4'd0:    c = 32'sd62330510;
            4'd1:    c = 32'sd47321429;
            4'd2:    c = 32'sd44878205;
            4'd3:    c = 32'sd28948859;
            4'd4:    c = 32'sd36148559;
            4'd5:    c = 32'sd15232707;
            4'd6:    c = 32'sd25209719;
            4'd7:    c = 32'sd5226188;
            4'd8:    c = 32'sd14599734;
            4'd9:    c = 32'sd852920;
            4'd10:   c = 32'sd6755006;
            4'd11:   c = -32'sd117318;
            4'd12:   c = 32'sd1923065;
            default: c = '0;
         endcase
      end
      return c;
   endfunction

endpackage

`default_nettype wire

@@ sv/fls_sine.sv @@
// Pipelined fixed-point sine: phase in turns (2^32 per turn) to Q2.30.
// Depends on fls_pkg; Horner polynomial, at most one multiply per stage.
`default_nettype none

module fls_sine import fls_pkg::*; (
   input  wire logic                        clock,
   input  wire logic                        adv,
   input  wire logic [PhaseWidth-1:0]       phase,
   output logic signed [TrigWidth-1:0]      sine
);

   localparam int HornerSteps = 6;

   logic [1:0]  quad0_ff, quad0_in;
   logic [30:0] t0_ff, t0_in;
   logic [1:0]  quad1_ff;
   logic [30:0] t1_ff;
   logic [61:0] tt_ff, tt_in;

   logic [1:0]                 quad_ff [0:HornerSteps];
   logic [30:0]                t_ff    [0:HornerSteps];
   logic [30:0]                t2_ff   [0:HornerSteps];
   logic signed [63:0]         prod_ff [0:HornerSteps];
   logic signed [63:0]         prod_in [0:HornerSteps];
   logic [30:0]                t2_in;

   logic signed [TrigWidth-1:0] mag;
   logic signed [TrigWidth-1:0] sine_ff, sine_in;

   // Fold the phase into the first quadrant
   always_comb begin
      quad0_in = phase[31:30];
      if (quad0_in[0]) begin
         t0_in = 31'(QuarterTurn) - {1'b0, phase[29:0]};
      end else begin
         t0_in = {1'b0, phase[29:0]};
      end
   end

   assign tt_in   = t0_ff * t0_ff;
   assign t2_in   = tt_ff[60:30];
   assign prod_in[0] = sine_poly(3'd6) * $signed({1'b0, t2_in});

   always_ff @(posedge clock) begin
      if (adv) begin
         quad0_ff   <= quad0_in;
         t0_ff      <= t0_in;
         quad1_ff   <= quad0_ff;
         t1_ff      <= t0_ff;
         tt_ff      <= tt_in;
         quad_ff[0] <= quad1_ff;
         t_ff[0]    <= t1_ff;
         t2_ff[0]   <= t2_in;
         prod_ff[0] <= prod_in[0];
      end
   end

   // One Horner step per stage: add the next term, then multiply
   for (genvar h = 1; h <= HornerSteps; h++) begin : g_horner
      logic signed [TrigWidth-1:0] acc;
      logic [30:0]                 opnd;
      assign acc  = sine_poly(3'(HornerSteps - h)) + prod_ff[h-1][61:30];
      assign opnd = (h < HornerSteps) ? t2_ff[h-1] : t_ff[h-1];
      assign prod_in[h] = acc * $signed({1'b0, opnd});

      always_ff @(posedge clock) begin
         if (adv) begin
            quad_ff[h] <= quad_ff[h-1];
            t_ff[h]    <= t_ff[h-1];
            t2_ff[h]   <= t2_ff[h-1];
            prod_ff[h] <= prod_in[h];
         end
      end
   end

   // Restore the sign for the lower half turn
   assign mag     = prod_ff[HornerSteps][61:30];
   assign sine_in = quad_ff[HornerSteps][1] ? -mag : mag;

   always_ff @(posedge clock) begin
      if (adv) begin
         sine_ff <= sine_in;
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

@@ sv/fls_cell.sv @@
// One harmonic cell: adds a_k*cos(k*theta) + b_k*sin(k*theta) to the running sum.
// Depends on fls_pkg and fls_sine.
`default_nettype none

module fls_cell import fls_pkg::*; #(
   parameter int HARMONIC = 1
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          adv,
   input  wire logic          in_vld,
   input  wire cell_data_type in_data,
   output logic               out_vld,
   output cell_data_type      out_data
);

   logic [PhaseWidth-1:0]       ph;
   logic signed [TrigWidth-1:0] cos_val, sin_val;

   logic          dly_vld_ff  [0:SineLatency-1];
   cell_data_type dly_data_ff [0:SineLatency-1];

   logic                        mul_vld_ff;
   cell_data_type               mul_data_ff;
   logic signed [63:0]          prod_a_ff, prod_a_in, prod_b_ff, prod_b_in;

   logic                        out_vld_ff;
   cell_data_type               out_data_ff, out_data_in;

   // Harmonic phase wraps modulo one turn
   assign ph = PhaseWidth'(in_data.theta * PhaseWidth'(HARMONIC));

   fls_sine u_cos (
      .clock (clock),
      .adv   (adv),
      .phase (ph + QuarterTurn),
      .sine  (cos_val)
   );

   fls_sine u_sin (
      .clock (clock),
      .adv   (adv),
      .phase (ph),
      .sine  (sin_val)
   );

   // Carry the item alongside the sine pipelines
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < SineLatency; j++) begin
            dly_vld_ff[j] <= 1'b0;
         end
      end else if (adv) begin
         dly_vld_ff[0] <= in_vld;
         for (int j = 1; j < SineLatency; j++) begin
            dly_vld_ff[j] <= dly_vld_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dly_data_ff[0] <= in_data;
         for (int j = 1; j < SineLatency; j++) begin
            dly_data_ff[j] <= dly_data_ff[j-1];
         end
      end
   end

   // Scale both trig values by this harmonic's coefficients
   assign prod_a_in = fit_coef(dly_data_ff[SineLatency-1].sel, 4'(2 * HARMONIC - 1)) * cos_val;
   assign prod_b_in = fit_coef(dly_data_ff[SineLatency-1].sel, 4'(2 * HARMONIC)) * sin_val;

   // Accumulate both floored terms, sign-extended to the running sum
   always_comb begin
      out_data_in     = mul_data_ff;
      out_data_in.acc = mul_data_ff.acc
                      + AccWidth'($signed(prod_a_ff[63:30]))
                      + AccWidth'($signed(prod_b_ff[63:30]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         mul_vld_ff <= dly_vld_ff[SineLatency-1];
         out_vld_ff <= mul_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mul_data_ff <= dly_data_ff[SineLatency-1];
         prod_a_ff   <= prod_a_in;
         prod_b_ff   <= prod_b_in;
         out_data_ff <= out_data_in;
      end
   end

   assign out_vld  = out_vld_ff;
   assign out_data = out_data_ff;

endmodule

`default_nettype wire

@@ sv/fourier_sensor_linearizer.sv @@
// Fourier sensor linearizer top level: phase stage, chain of harmonic cells, output clamp.
// Depends on fls_pkg and fls_cell.
`default_nettype none

// Turns a raw hall-sensor sample into position (signed Q8.16 mm) from a fixed
// Fourier fit for the selected sensor. One beat is taken every clock unless the
// output stalls; each request passes through one phase stage, one cell of
// twelve stages per harmonic (ten for the pipelined sine, one multiply, one
// accumulate) and the output register. The chain advances as a whole: it halts
// only while a result sits in the output register and rsp_ready is low.
// saturated marks results clamped to 24 bits.
module fourier_sensor_linearizer import fls_pkg::*; #(
   parameter int SAMPLE_BITS    = SampleBitsDefault,
   parameter int HARMONIC_COUNT = HarmonicCountDefault
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic                  adv;
   logic [SampleWidth-1:0] count;

   logic          link_vld  [0:HARMONIC_COUNT];
   cell_data_type link_data [0:HARMONIC_COUNT];

   logic          in_vld_ff;
   cell_data_type in_data_ff, in_data_in;

   logic signed [AccWidth-1:0]   rounded;
   logic signed [AccWidth-9:0]   q;
   rsp_type                      rsp_ff, rsp_in;
   logic                         rsp_valid_ff;

   // Advance everything unless a result is held
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Scale the sample up to the 16-bit span, shifting out the unused high bits
   assign count = req_data.sample << (SampleWidth - SAMPLE_BITS);

   always_comb begin
      in_data_in.sel   = req_data.sensor_select;
      in_data_in.theta = PhaseWidth'(count) * PhaseWidth'(phase_step(req_data.sensor_select));
      in_data_in.acc   = AccWidth'(fit_coef(req_data.sensor_select, 4'd0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (adv) begin
         in_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         in_data_ff <= in_data_in;
      end
   end

   assign link_vld[0]  = in_vld_ff;
   assign link_data[0] = in_data_ff;

   // One cell per harmonic
   for (genvar k = 1; k <= HARMONIC_COUNT; k++) begin : g_cell
      fls_cell #(
         .HARMONIC (k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .adv      (adv),
         .in_vld   (link_vld[k-1]),
         .in_data  (link_data[k-1]),
         .out_vld  (link_vld[k]),
         .out_data (link_data[k])
      );
   end

   // Round to Q8.16 and clamp
   assign rounded = link_data[HARMONIC_COUNT].acc + AccWidth'(128);
   assign q       = rounded[AccWidth-1:8];

   always_comb begin
      priority if (q > (AccWidth-8)'(PosMax)) begin
         rsp_in.position  = PosMax;
         rsp_in.saturated = 1'b1;
      end else if (q < (AccWidth-8)'(PosMin)) begin
         rsp_in.position  = PosMin;
         rsp_in.saturated = 1'b1;
      end else begin
         rsp_in.position  = q[PosWidth-1:0];
         rsp_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= link_vld[HARMONIC_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for fourier_sensor_linearizer: drives sample beats, predicts the position in place
// and checks every result beat in order. Depends on fls_pkg and the block's RTL.
`default_nettype none

module tb;
   import fls_pkg::*;

   localparam int Latency   = 2 + 12 * HarmonicCountDefault;
   localparam int IdleLimit = 20000;
   localparam int RandItems = 1100;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_q[$];
   rsp_type position_q[$];
   int      errors = 0;
   int      beats_in = 0;
   int      beats_out = 0;
   int      sat_seen = 0;
   int      idle_cycles = 0;
   bit      stim_done = 1'b0;
   bit      hold_rsp = 1'b0;
   bit      drain_wait = 1'b0;

   fourier_sensor_linearizer i_dut (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Floor shift of a signed 64-bit value
   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   // Sine of a turn fraction, Q2.30
   function automatic longint turn_sine(logic [31:0] p);
      logic [1:0] quad;
      longint t, t2, acc;
      quad = p[31:30];
      t = longint'(p[29:0]);
      if (quad[0]) t = (longint'(1) << 30) - t;
      t2 = floor_shift(t * t, 30);
      acc = longint'(sine_poly(3'd6));
      for (int i = 5; i >= 0; i--)
         acc = longint'(sine_poly(3'(i))) + floor_shift(acc * t2, 30);
      acc = floor_shift(acc * t, 30);
      return quad[1] ? -acc : acc;
   endfunction

   // Fourier-series position of one sample beat
   function automatic rsp_type fit_position(req_type r);
      rsp_type    res;
      logic [31:0] theta, ph;
      longint     acc, q;
      theta = 32'(r.sample) * 32'(phase_step(r.sensor_select));
      acc = longint'(fit_coef(r.sensor_select, 4'd0));
      for (int k = 1; k <= HarmonicCountDefault; k++) begin
         ph = 32'(k) * theta;
         acc += floor_shift(longint'(fit_coef(r.sensor_select, 4'(2*k-1)))
                            * turn_sine(ph + QuarterTurn), 30);
         acc += floor_shift(longint'(fit_coef(r.sensor_select, 4'(2*k)))
                            * turn_sine(ph), 30);
      end
      q = floor_shift(acc + 128, 8);
      res.saturated = 1'b0;
      if (q > 64'sd8388607) begin
         q = 8388607; res.saturated = 1'b1;
      end else if (q < -64'sd8388608) begin
         q = -8388608; res.saturated = 1'b1;
      end
      res.position = q[23:0];
      return res;
   endfunction

   // Driver: bursts with random gaps; pauses for a full drain when asked
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            position_q.push_back(fit_position(req_data));
            beats_in++;
         end
         if (req_valid && !req_ready) begin
            // hold the beat
         end else if (drain_wait && position_q.size() != 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_q.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_q.pop_front();
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(40, 1);
               gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern, with one long hold-off
   int stall_phase = 0;
   always @(posedge clock) begin
      stall_phase <= (stall_phase + 1) % 23;
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else if (stall_phase < 8) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(3) != 0);
   end

   // Monitor: compare result beats against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (position_q.size() == 0) begin
            $error("result beat with no prediction waiting");
            errors++;
         end else begin
            rsp_type exp_rsp;
            exp_rsp = position_q.pop_front();
            if (rsp_data.position !== exp_rsp.position) begin
               $error("position: expected %0d, actual %0d",
                      exp_rsp.position, rsp_data.position);
               errors++;
            end
            if (rsp_data.saturated !== exp_rsp.saturated) begin
               $error("saturated: expected %0b, actual %0b",
                      exp_rsp.saturated, rsp_data.saturated);
               errors++;
            end
            if (rsp_data.saturated) sat_seen++;
         end
      end
   end

   // Watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   function automatic req_type make_req(logic sel, logic [15:0] s);
      req_type r;
      r.sensor_select = sel;
      r.sample = s;
      return r;
   endfunction

   initial begin
      logic [15:0] s;
      // Directed: sample extremes, single bits and phase corners on both sensors
      for (int sel = 0; sel < 2; sel++) begin
         pending_q.push_back(make_req(sel[0], 16'h0000));
         pending_q.push_back(make_req(sel[0], 16'hFFFF));
         pending_q.push_back(make_req(sel[0], 16'h8000));
         pending_q.push_back(make_req(sel[0], 16'h7FFF));
         pending_q.push_back(make_req(sel[0], 16'h0001));
         pending_q.push_back(make_req(sel[0], 16'h5555));
         pending_q.push_back(make_req(sel[0], 16'hAAAA));
         pending_q.push_back(make_req(sel[0], 16'h4000));
         pending_q.push_back(make_req(sel[0], 16'hC000));
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Random part, with a long receiver hold-off and a drain pause mid-run
      for (int i = 0; i < RandItems; i++) begin
         case ($urandom_range(3))
            0: s = 16'($urandom_range(255));
            1: s = 16'hFFFF - 16'($urandom_range(255));
            default: s = 16'($urandom());
         endcase
         pending_q.push_back(make_req(1'($urandom()), s));
      end
      while (beats_in <= 300) @(posedge clock);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (400) @(posedge clock);
      hold_rsp <= 1'b0;
      while (beats_in <= 700) @(posedge clock);
      @(posedge clock);
      drain_wait <= 1'b1;
      @(posedge clock);
      while (position_q.size() != 0) @(posedge clock);
      @(posedge clock);
      drain_wait <= 1'b0;

      while (pending_q.size() != 0 || req_valid) @(posedge clock);
      stim_done = 1'b1;
      while (position_q.size() != 0) @(posedge clock);
      repeat (Latency + 10) @(posedge clock);
      $display("Checked %0d sample beats over both sensors, %0d results, %0d clamped.",
               beats_in, beats_out, sat_seen);
      if (errors == 0 && position_q.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule

`default_nettype wire

@@ sim.f @@
sv/fls_pkg.sv
sv/fls_sine.sv
sv/fls_cell.sv
sv/fourier_sensor_linearizer.sv
sim/tb.sv
